FILE: sv/whb_pkg.sv
// Shared types and constants of the weighted histogram engine.
package whb_pkg;

  localparam int BIN_COUNT_DEF = 1024;
  localparam int IDX_W         = 17;
  localparam int CAP_W         = 11;
  localparam int TOTAL_W       = 32;
  localparam int VALUE_W       = 16;
  localparam int WEIGHT_W      = 16;
  localparam int READ_BIN_W    = 10;
  localparam int APB_ADDR_W    = 3;
  localparam int APB_DATA_W    = 32;

  localparam logic [CAP_W-1:0]    BIN_CAP_RST = 11'd1024;
  localparam logic [WEIGHT_W-1:0] UNIT_WEIGHT = 16'd256;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic REG_BIN_CAP       = 1'b0;
  localparam logic REG_WEIGHTED_MODE = 1'b1;

  typedef struct packed {
    logic                       kind;
    logic signed [VALUE_W-1:0]  sample_value;
    logic signed [WEIGHT_W-1:0] sample_weight;
    logic [READ_BIN_W-1:0]      read_bin;
    logic                       read_final;
  } in_word_t;

  typedef struct packed {
    logic signed [TOTAL_W-1:0] bin_total;
    logic [CAP_W-1:0]          used_length;
  } out_word_t;

  typedef struct packed {
    logic                      add;
    logic signed [VALUE_W-1:0] value;
    logic                      final_clear;
  } trk_req_t;

endpackage

FILE: sv/whb_bin_ram.sv
// Bin store: one write port, one read port with registered read data.
module whb_bin_ram
  import whb_pkg::*;
#(
  parameter int DEPTH = BIN_COUNT_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic [TOTAL_W-1:0] rd_data,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [TOTAL_W-1:0] wr_data
);

  logic [TOTAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/whb_tracker.sv
// Largest-value tracker and output length computation.
module whb_tracker
  import whb_pkg::*;
#(
  parameter int BIN_COUNT = BIN_COUNT_DEF,
  parameter int AW        = $clog2(BIN_COUNT)
) (
  input  logic             clk,
  input  logic             rst,
  input  trk_req_t         req,
  input  logic [CAP_W-1:0] cap,
  output logic [CAP_W-1:0] used_length
);

  localparam logic [IDX_W-1:0] LAST = IDX_W'(BIN_COUNT - 1);

  logic          any_seen;
  logic [AW-1:0] largest_seen;
  logic [IDX_W-1:0] value_ext;
  logic [IDX_W-1:0] clipped;
  logic [IDX_W-1:0] len_raw;
  logic [IDX_W-1:0] cap_ext;

  assign value_ext = {1'b0, req.value};
  assign clipped   = (value_ext > LAST) ? LAST : value_ext;
  assign len_raw   = IDX_W'(largest_seen) + IDX_W'(1);
  assign cap_ext   = IDX_W'(cap);

  always_comb begin
    if (!any_seen) begin
      used_length = '0;
    end else if (len_raw > cap_ext) begin
      used_length = cap;
    end else begin
      used_length = len_raw[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      any_seen     <= 1'b0;
      largest_seen <= '0;
    end else if (req.add && !req.value[VALUE_W-1]) begin
      any_seen <= 1'b1;
      if (!any_seen || clipped > IDX_W'(largest_seen)) begin
        largest_seen <= clipped[AW-1:0];
      end
    end else if (req.final_clear) begin
      any_seen     <= 1'b0;
      largest_seen <= '0;
    end
  end

endmodule

FILE: sv/weighted_bincount_histogram_top.sv
// Weighted histogram engine: APB registers, bin store update pipeline, output register.
// Throughput: one word per cycle unless an output stall or the clearing pass holds off
// input; the bin store read-modify-write forwards back to back. A read word's result
// passes the stage-1 and output registers. Add words produce no result; an output stall
// holds only a pending read word. Reset: synchronous; after reset a clearing pass
// zeroes the bin store; no word is accepted meanwhile (register writes are taken).
module weighted_bincount_histogram_top
  import whb_pkg::*;
#(
  parameter int BIN_COUNT = BIN_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data
);

  localparam int               AW = $clog2(BIN_COUNT);
  localparam logic [IDX_W-1:0] BC = IDX_W'(BIN_COUNT);
  localparam logic [AW-1:0]    LAST_ADDR = AW'(BIN_COUNT - 1);

  logic [CAP_W-1:0] bin_cap;
  logic             weighted_mode;
  logic             reg_sel;

  logic          clearing;
  logic [AW-1:0] clr_addr;

  logic                       s1_valid;
  logic                       s1_read;
  logic                       s1_wr;
  logic [AW-1:0]              s1_addr;
  logic signed [WEIGHT_W-1:0] s1_incr;
  logic [CAP_W-1:0]           s1_len;

  logic               wb_valid;
  logic [AW-1:0]      wb_addr;
  logic [TOTAL_W-1:0] wb_data;

  logic [IDX_W-1:0] cap_full;
  logic [CAP_W-1:0] cap;
  logic [IDX_W-1:0] value_ext;
  logic [IDX_W-1:0] bin_ext;
  logic             is_add;
  logic             add_hit;
  logic             read_hit;
  logic             accept;
  logic             stall;
  logic             fire;
  logic [AW-1:0]    a_addr;

  logic [TOTAL_W-1:0] rd_data;
  logic [TOTAL_W-1:0] old_val;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] sat_val;
  logic [TOTAL_W-1:0] new_val;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [TOTAL_W-1:0] ram_wdata;

  trk_req_t         trk_req;
  logic [CAP_W-1:0] used_length;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_comb begin
    case (reg_sel)
      REG_BIN_CAP:       prdata = APB_DATA_W'(bin_cap);
      REG_WEIGHTED_MODE: prdata = APB_DATA_W'(weighted_mode);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_cap       <= BIN_CAP_RST;
      weighted_mode <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_BIN_CAP:       bin_cap <= pwdata[CAP_W-1:0];
        REG_WEIGHTED_MODE: weighted_mode <= pwdata[0];
        default:           ;
      endcase
    end
  end

  assign cap_full  = (IDX_W'(bin_cap) > BC) ? BC : IDX_W'(bin_cap);
  assign cap       = cap_full[CAP_W-1:0];
  assign value_ext = {1'b0, in_data.sample_value};
  assign bin_ext   = IDX_W'(in_data.read_bin);
  assign is_add    = (in_data.kind == KIND_ADD);
  assign add_hit   = !in_data.sample_value[VALUE_W-1] && (value_ext < cap_full);
  assign read_hit  = (bin_ext < BC);
  assign a_addr    = is_add ? value_ext[AW-1:0] : bin_ext[AW-1:0];

  assign stall    = s1_valid && s1_read && out_valid && !out_ready;
  assign fire     = s1_valid && !stall;
  assign in_ready = !clearing && !stall;
  assign accept   = in_valid && in_ready;

  assign trk_req.add         = accept && is_add;
  assign trk_req.value       = in_data.sample_value;
  assign trk_req.final_clear = accept && !is_add && in_data.read_final;

  whb_tracker #(
    .BIN_COUNT (BIN_COUNT),
    .AW        (AW)
  ) u_tracker (
    .clk         (clk),
    .rst         (rst),
    .req         (trk_req),
    .cap         (cap),
    .used_length (used_length)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_read <= !is_add;
      s1_wr   <= is_add ? add_hit : read_hit;
      s1_addr <= a_addr;
      s1_incr <= weighted_mode ? in_data.sample_weight : UNIT_WEIGHT;
      s1_len  <= used_length;
    end
  end

  assign old_val = (wb_valid && wb_addr == s1_addr) ? wb_data : rd_data;
  assign sum     = {old_val[TOTAL_W-1], old_val} + (TOTAL_W+1)'(s1_incr);

  always_comb begin
    if (sum[TOTAL_W] != sum[TOTAL_W-1]) begin
      sat_val = sum[TOTAL_W] ? {1'b1, {(TOTAL_W-1){1'b0}}} : {1'b0, {(TOTAL_W-1){1'b1}}};
    end else begin
      sat_val = sum[TOTAL_W-1:0];
    end
  end

  assign new_val = s1_read ? '0 : sat_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
    end
  end

  assign ram_we    = clearing || (fire && s1_wr);
  assign ram_waddr = clearing ? clr_addr : s1_addr;
  assign ram_wdata = clearing ? '0 : new_val;

  always_ff @(posedge clk) begin
    if (rst || clearing) begin
      wb_valid <= 1'b0;
    end else if (fire && s1_wr) begin
      wb_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s1_wr) begin
      wb_addr <= s1_addr;
      wb_data <= new_val;
    end
  end

  whb_bin_ram #(
    .DEPTH (BIN_COUNT),
    .AW    (AW)
  ) u_bin_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (a_addr),
    .rd_data (rd_data),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && s1_read) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s1_read) begin
      out_data.bin_total   <= s1_wr ? old_val : '0;
      out_data.used_length <= s1_len;
    end
  end

endmodule
